/* src/box_blur_white_border_top_macros.svh */
// Assertion macros shared by the box blur checker.
`ifndef BOX_BLUR_WHITE_BORDER_TOP_MACROS_SVH
`define BOX_BLUR_WHITE_BORDER_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define BBW_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("box blur check failed");

// Next-cycle implication, off while in reset.
`define BBW_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("box blur check failed");

// Property that must hold in the cycle after reset is applied.
`define BBW_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> (prop)) \
    else $error("box blur reset check failed");

`endif

/* src/bbw_pkg.sv */
// Shared types and constants for the box blur with white border.
package bbw_pkg;

  localparam int KERNEL_DEF    = 9;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CFG_DW        = 11;
  localparam int HGT_W         = 11;
  localparam int ROW_W         = 12;

  localparam logic [CFG_DW-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_DW-1:0] RST_HEIGHT = 11'd480;
  localparam logic [7:0]        BORDER     = 8'd255;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       func;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       end_of_row;
    logic       end_of_frame;
  } out_t;

  // blue in the low byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic             emit;
    logic             eor;
    logic             eof;
    logic [ROW_W-1:0] row;
    pix_t             pix;
  } step_t;

endpackage

/* src/box_blur_white_border_top.sv */
// Top level of the streaming box blur with white border.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_data  | pixel or flush request
//  output  | out_valid / out_ready/out_data | blurred pixel with row/frame end
//  config  | cfg_we / cfg_idx / cfg_data    | register write, no handshake
//
// One request per cycle while in_ready is high; a result passes the stage
// registers after the request that completes its window (h*W+h pixels later,
// h = KERNEL/2), the rate limited by the one read-modify-write of the column
// line memory per step. If a frame is shorter than that lag, up to h*W+h-1
// internal steps run at drain start before flush requests are taken.
// Synchronous reset clears positions and sets 640 x 480; the line memory is
// never cleared. A stalled output backs up through the stage registers.
module box_blur_white_border_top #(
  parameter int KERNEL    = bbw_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH = bbw_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  bbw_pkg::cfg_idx_t          cfg_idx,
  input  logic [bbw_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bbw_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbw_pkg::out_t              out_data
);
  import bbw_pkg::*;

  logic                           s1_ready, step_valid;
  step_t                          step;
  logic [$clog2(MAX_WIDTH)-1:0]   step_col, step_ocol;
  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w;
  logic [HGT_W-1:0]               eff_h;

  bbw_front #(
    .KERNEL    (KERNEL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .s1_ready   (s1_ready),
    .step_valid (step_valid),
    .step       (step),
    .step_col   (step_col),
    .step_ocol  (step_ocol),
    .eff_w      (eff_w),
    .eff_h      (eff_h)
  );

  bbw_filter #(
    .KERNEL    (KERNEL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .step_col   (step_col),
    .step_ocol  (step_ocol),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .s1_ready   (s1_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* src/bbw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/bbw_front.sv */
// Position sequencer: config registers, raster counters and step issue.
module bbw_front #(
  parameter int KERNEL    = bbw_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH = bbw_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  bbw_pkg::cfg_idx_t                cfg_idx,
  input  logic [bbw_pkg::CFG_DW-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bbw_pkg::in_t                     in_data,
  input  logic                             s1_ready,
  output logic                             step_valid,
  output bbw_pkg::step_t                   step,
  output logic [$clog2(MAX_WIDTH)-1:0]     step_col,
  output logic [$clog2(MAX_WIDTH)-1:0]     step_ocol,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  output logic [bbw_pkg::HGT_W-1:0]        eff_h
);
  import bbw_pkg::*;

  localparam int HALF = KERNEL / 2;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int VW   = $clog2((MAX_HEIGHT + KERNEL + 1) * MAX_WIDTH);

  logic [CFG_DW-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [HGT_W-1:0]  out_row_r, out_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [VW-1:0]     vcnt_r, vcnt_nxt;

  logic [VW-1:0] lag;
  logic [CW-1:0] last_col;
  logic          draining, early, auto_step, emit, eor, eof;

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HGT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(height_r);
    end
  end

  assign lag      = VW'(HALF * int'(eff_w) + HALF);
  assign last_col = CW'(eff_w - WW'(1));
  assign draining = int'(in_row_r) >= int'(eff_h);
  assign early    = vcnt_r < lag;

  // once the frame is in, walk border positions on our own until results are due
  assign auto_step  = draining && early && !cfg_we && s1_ready;
  assign in_ready   = s1_ready && !(draining && early) && !cfg_we;
  assign step_valid = auto_step ||
                      (in_valid && in_ready && (draining || !in_data.func));

  assign emit = !early;
  assign eor  = out_col_r == last_col;
  assign eof  = eor && (out_row_r == HGT_W'(eff_h - HGT_W'(1)));

  assign step.emit       = emit;
  assign step.eor        = eor;
  assign step.eof        = eof;
  assign step.row        = in_row_r;
  assign step.pix.red    = in_data.in_red;
  assign step.pix.green  = in_data.in_green;
  assign step.pix.blue   = in_data.in_blue;
  assign step_col        = in_col_r;
  assign step_ocol       = out_col_r;

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    vcnt_nxt    = vcnt_r;
    if (cfg_we) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      vcnt_nxt    = '0;
      case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end else if (step_valid) begin
      if (emit && eof) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        vcnt_nxt    = '0;
      end else begin
        vcnt_nxt = vcnt_r + 1'b1;
        if (in_col_r == last_col) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 1'b1;
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
        if (emit) begin
          if (eor) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      vcnt_r    <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      vcnt_r    <= vcnt_nxt;
    end
  end

endmodule

/* src/bbw_filter.sv */
// Filter datapath: column line memory, vertical sums, horizontal window, divide.
module bbw_filter #(
  parameter int KERNEL    = bbw_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH = bbw_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_valid,
  input  bbw_pkg::step_t                   step,
  input  logic [$clog2(MAX_WIDTH)-1:0]     step_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]     step_ocol,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  input  logic [bbw_pkg::HGT_W-1:0]        eff_h,
  output logic                             s1_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bbw_pkg::out_t                    out_data
);
  import bbw_pkg::*;

  localparam int HALF       = KERNEL / 2;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int LW         = 24 * (KERNEL - 1);
  localparam int CSW        = $clog2(KERNEL * 255 + 1);
  localparam int SUMW       = $clog2(KERNEL * KERNEL * 255 + 1);
  localparam int KK         = KERNEL * KERNEL;
  localparam int SH         = SUMW;
  localparam int RECIP      = (1 << SH) / KK;
  localparam int PW         = SUMW + SH;
  localparam int BORDER_COL = KERNEL * 255;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage 1: line memory read data arrives
  step_t         st1_r;
  logic [CW-1:0] c1_r, oc1_r;
  logic          fwd_r;
  logic [LW-1:0] fwdd_r;
  logic [LW-1:0] rdata, entry, wdata;
  logic          wr_en;
  logic [2:0][CSW-1:0] cs1;

  // stage 2: column sums
  logic [2:0][CSW-1:0] cs2_r;
  logic                e2_r, eor2_r, eof2_r;
  logic [CW-1:0]       oc2_r;

  // stage 3: horizontal taps
  logic [2:0][CSW-1:0] taps_r [KERNEL];
  logic                e3_r, eor3_r, eof3_r;
  logic [CW-1:0]       oc3_r;
  logic [2:0][SUMW-1:0] sum3;

  // stage 4..6: window sum, reciprocal multiply, correction
  logic [2:0][SUMW-1:0] sum4_r, sum5_r;
  logic                 eor4_r, eof4_r, eor5_r, eof5_r;
  logic [2:0][7:0]      q5_r;
  logic [2:0][7:0]      q5_nxt;
  logic [2:0][7:0]      qf;
  out_t                 od6_r;

  assign rdy6 = !v6_r || out_ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || !e3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign s1_ready = rdy1;

  assign wr_en = v1_r && rdy2;

  bbw_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (c1_r),
    .wdata (wdata),
    .re    (step_valid),
    .raddr (step_col),
    .rdata (rdata)
  );

  always_comb begin
    entry = fwd_r ? fwdd_r : rdata;
    for (int ch = 0; ch < 3; ch++) begin
      if (int'(st1_r.row) < int'(eff_h)) begin
        cs1[ch] = CSW'(st1_r.pix[8*ch +: 8]);
      end else begin
        cs1[ch] = CSW'(BORDER);
      end
      for (int k = 0; k < KERNEL - 1; k++) begin
        if (int'(st1_r.row) > k && int'(st1_r.row) < int'(eff_h) + 1 + k) begin
          cs1[ch] = cs1[ch] + CSW'(entry[24*k + 8*ch +: 8]);
        end else begin
          cs1[ch] = cs1[ch] + CSW'(BORDER);
        end
      end
    end
    // age every stored row by one and put the new pixel on top
    wdata = {entry[LW-25:0], st1_r.pix};
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum3[ch] = '0;
      for (int j = 0; j < KERNEL; j++) begin
        if (int'(oc3_r) + HALF - j >= 0 && int'(oc3_r) + HALF - j < int'(eff_w)) begin
          sum3[ch] = sum3[ch] + SUMW'(taps_r[j][ch]);
        end else begin
          sum3[ch] = sum3[ch] + SUMW'(BORDER_COL);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q5_nxt[ch] = 8'((PW'(sum4_r[ch]) * PW'(RECIP)) >> SH);
    end
  end

  // estimate is low by at most one
  always_comb begin
    logic [SUMW-1:0] rem;
    for (int ch = 0; ch < 3; ch++) begin
      rem = sum5_r[ch] - SUMW'(q5_r[ch]) * SUMW'(KK);
      qf[ch] = (rem >= SUMW'(KK)) ? q5_r[ch] + 8'd1 : q5_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= step_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r && e3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_valid) begin
      st1_r  <= step;
      c1_r   <= step_col;
      oc1_r  <= step_ocol;
      // the read misses a write to the same column landing on this edge
      fwd_r  <= wr_en && (c1_r == step_col);
      fwdd_r <= wdata;
    end
    if (v1_r && rdy2) begin
      cs2_r  <= cs1;
      e2_r   <= st1_r.emit;
      eor2_r <= st1_r.eor;
      eof2_r <= st1_r.eof;
      oc2_r  <= oc1_r;
    end
    if (v2_r && rdy3) begin
      taps_r[0] <= cs2_r;
      for (int j = 1; j < KERNEL; j++) begin
        taps_r[j] <= taps_r[j-1];
      end
      e3_r   <= e2_r;
      eor3_r <= eor2_r;
      eof3_r <= eof2_r;
      oc3_r  <= oc2_r;
    end
    if (v3_r && e3_r && rdy4) begin
      sum4_r <= sum3;
      eor4_r <= eor3_r;
      eof4_r <= eof3_r;
    end
    if (v4_r && rdy5) begin
      q5_r   <= q5_nxt;
      sum5_r <= sum4_r;
      eor5_r <= eor4_r;
      eof5_r <= eof4_r;
    end
    if (v5_r && rdy6) begin
      od6_r.out_blue     <= qf[0];
      od6_r.out_green    <= qf[1];
      od6_r.out_red      <= qf[2];
      od6_r.end_of_row   <= eor5_r;
      od6_r.end_of_frame <= eof5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data  = od6_r;

endmodule

/* src/bbw_checker.sv */
// Port-level checker for the box blur top level, with its bind.
`include "box_blur_white_border_top_macros.svh"

module bbw_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input bbw_pkg::out_t out_data
);

  `BBW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `BBW_ASSERT_RST(a_rst_idle, !out_valid)
  `BBW_ASSERT_NOW(a_eof_eor, out_valid && out_data.end_of_frame, out_data.end_of_row)

endmodule

bind box_blur_white_border_top bbw_checker u_bbw_checker (.*);
